// File: hdl/bcmf_pkg.sv
// shared types and constants of the binary cross morphology filter
package bcmf_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam int MODE_W   = 3;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // largest frame height; larger register values clamp to it
  localparam logic [HEIGHT_W-1:0] ROW_LIMIT = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_INVERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ERODE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DILATE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AVERAGE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ZERO   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0]   RESET_MODE   = MODE_INVERT;
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd1024;

  typedef struct packed {
    logic func;
    logic pixel_in;
  } in_item_t;

  typedef struct packed {
    logic pixel_out;
    logic end_of_row;
    logic end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic      push;
    out_item_t item;
  } core_res_t;

endpackage

// File: hdl/bcmf_core.sv
// line store, raster counters and cross window logic of the filter
module bcmf_core #(
  parameter int MAX_WIDTH = bcmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bcmf_pkg::cfg_t      cfg,
  input  logic                accept,
  input  bcmf_pkg::in_item_t  item,
  output bcmf_pkg::core_res_t res
);
  import bcmf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int HD = (MAX_WIDTH + 1) / 2;
  localparam int HW = (HD > 1) ? $clog2(HD) : 1;

  // line store split by column parity, each word holds both row banks
  logic [1:0] mem_ev [HD];
  logic [1:0] mem_od [HD];

  logic [CW-1:0]    icol_r, icol_nxt, ocol_r, ocol_nxt;
  logic [ROW_W-1:0] irow_r, irow_nxt, orow_r, orow_nxt;
  logic             fc_r, fc_nxt;

  logic [WW-1:0]       eff_w;
  logic [HEIGHT_W-1:0] eff_h;

  logic is_pix, is_flush, has_res;
  logic ic_end, ir_end, eor, eof;

  logic [1:0] ev0_r, ev1_r, od0_r, od1_r;
  logic       ev0_hit_r, ev1_hit_r, od0_hit_r, od1_hit_r;
  logic       ev0_hit_nxt, ev1_hit_nxt, od0_hit_nxt, od1_hit_nxt;
  logic       wbank_r, wpix_r;

  logic [CW-1:0] rd_col;
  logic [HW-1:0] ra_h, ra_hp1, ra_hm1, widx;
  logic [HW:0]   hp1_wide;
  logic          we;

  logic [1:0] wc, wl, wr;
  logic       rb, centre, up_d, dn_d, lf_d, rt_d, down, pix_res;
  logic [2:0] dis;

  function automatic logic [1:0] merge(logic [1:0] word, logic hit, logic bank, logic pix);
    logic [1:0] m;
    m = word;
    if (hit) m[bank] = pix;
    return m;
  endfunction

  // clamp the size registers
  always_comb begin
    if (cfg.image_width == '0) eff_w = WW'(1);
    else if (int'(cfg.image_width) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(cfg.image_width);
    if (cfg.image_height == '0) eff_h = HEIGHT_W'(1);
    else if (cfg.image_height > ROW_LIMIT) eff_h = ROW_LIMIT;
    else eff_h = cfg.image_height;
  end

  assign is_pix   = accept && !item.func && !fc_r;
  assign is_flush = accept && item.func && fc_r;
  assign has_res  = (is_pix && (irow_r != '0)) || is_flush;
  assign down     = is_pix ? item.pixel_in : 1'b0;

  assign ic_end = ({1'b0, icol_r} + WW'(1)) >= eff_w;
  assign ir_end = ({1'b0, irow_r} + HEIGHT_W'(1)) >= eff_h;
  assign eor    = ({1'b0, ocol_r} + WW'(1)) >= eff_w;
  assign eof    = eor && (({1'b0, orow_r} + HEIGHT_W'(1)) >= eff_h);

  // window words of the current output position
  always_comb begin
    if (!ocol_r[0]) begin
      wc = merge(ev0_r, ev0_hit_r, wbank_r, wpix_r);
      wl = merge(od1_r, od1_hit_r, wbank_r, wpix_r);
      wr = merge(od0_r, od0_hit_r, wbank_r, wpix_r);
    end else begin
      wc = merge(od0_r, od0_hit_r, wbank_r, wpix_r);
      wl = merge(ev0_r, ev0_hit_r, wbank_r, wpix_r);
      wr = merge(ev1_r, ev1_hit_r, wbank_r, wpix_r);
    end
  end

  always_comb begin
    rb     = orow_r[0];
    centre = wc[rb];
    up_d   = (orow_r != '0) && (wc[~rb] != centre);
    dn_d   = (({1'b0, orow_r} + HEIGHT_W'(1)) < eff_h) && (down != centre);
    lf_d   = (ocol_r != '0) && (wl[rb] != centre);
    rt_d   = (({1'b0, ocol_r} + WW'(1)) < eff_w) && (wr[rb] != centre);
    dis    = 3'(up_d) + 3'(dn_d) + 3'(lf_d) + 3'(rt_d);
    unique case (cfg.mode)
      MODE_INVERT:  pix_res = ~centre;
      MODE_ERODE:   pix_res = centre && (dis == '0);
      MODE_DILATE:  pix_res = centre || (dis != '0);
      MODE_AVERAGE: pix_res = (dis > 3'd2) ? ~centre : centre;
      MODE_ZERO:    pix_res = 1'b0;
      default:      pix_res = centre;
    endcase
  end

  always_comb begin
    res.push              = has_res;
    res.item.pixel_out    = pix_res;
    res.item.end_of_row   = eor;
    res.item.end_of_frame = eof;
  end

  // counter update, end of frame clears everything
  always_comb begin
    icol_nxt = icol_r;
    irow_nxt = irow_r;
    fc_nxt   = fc_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (is_pix) begin
      if (ic_end) begin
        icol_nxt = '0;
        if (ir_end) fc_nxt = 1'b1;
        else irow_nxt = irow_r + ROW_W'(1);
      end else begin
        icol_nxt = icol_r + CW'(1);
      end
    end
    if (has_res) begin
      if (eof) begin
        icol_nxt = '0;
        irow_nxt = '0;
        fc_nxt   = 1'b0;
        ocol_nxt = '0;
        orow_nxt = '0;
      end else if (eor) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + ROW_W'(1);
      end else begin
        ocol_nxt = ocol_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icol_r <= '0;
      irow_r <= '0;
      fc_r   <= 1'b0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      icol_r <= icol_nxt;
      irow_r <= irow_nxt;
      fc_r   <= fc_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  // read ahead at the position the counters move to
  always_comb begin
    rd_col   = rst_n ? ocol_nxt : '0;
    ra_h     = HW'(rd_col >> 1);
    hp1_wide = {1'b0, ra_h} + (HW + 1)'(1);
    ra_hp1   = (int'(hp1_wide) < HD) ? HW'(hp1_wide) : ra_h;
    ra_hm1   = (ra_h == '0) ? ra_h : ra_h - HW'(1);
    we       = is_pix;
    widx     = HW'(icol_r >> 1);
    ev0_hit_nxt = we && !icol_r[0] && (widx == ra_h);
    ev1_hit_nxt = we && !icol_r[0] && (widx == ra_hp1);
    od0_hit_nxt = we && icol_r[0] && (widx == ra_h);
    od1_hit_nxt = we && icol_r[0] && (widx == ra_hm1);
  end

  always_ff @(posedge clk) begin
    if (we && !icol_r[0]) mem_ev[widx][irow_r[0]] <= item.pixel_in;
    if (we && icol_r[0])  mem_od[widx][irow_r[0]] <= item.pixel_in;
    ev0_r <= mem_ev[ra_h];
    ev1_r <= mem_ev[ra_hp1];
    od0_r <= mem_od[ra_h];
    od1_r <= mem_od[ra_hm1];
    ev0_hit_r <= ev0_hit_nxt;
    ev1_hit_r <= ev1_hit_nxt;
    od0_hit_r <= od0_hit_nxt;
    od1_hit_r <= od1_hit_nxt;
    wbank_r   <= irow_r[0];
    wpix_r    <= item.pixel_in;
  end

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res.push && res.item.end_of_frame |=> ocol_r == '0 && orow_r == '0 &&
      icol_r == '0 && irow_r == '0 && !fc_r)
    else $error("counters not cleared after end of frame");

  a_done_col: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r |-> icol_r == '0)
    else $error("input column moved after frame end");

  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !item.func && !fc_r && irow_r == '0 |-> !res.push)
    else $error("result from a first row pixel");

  a_early_flush: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.func && !fc_r |-> !res.push)
    else $error("result from a flush before frame end");

endmodule

// File: hdl/bcmf_obuf.sv
// two entry result buffer between the filter core and the output channel
module bcmf_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  bcmf_pkg::core_res_t res,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output bcmf_pkg::out_item_t out_data
);
  import bcmf_pkg::*;

  out_item_t  slot0_r, slot1_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = slot0_r;
  assign space     = cnt_r != 2'd2;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (res.push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !res.push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (res.push && cnt_r == 2'd1) slot0_r <= res.item;
      else slot0_r <= slot1_r;
    end else if (res.push && cnt_r == 2'd0) begin
      slot0_r <= res.item;
    end
    if (res.push && ((cnt_r == 2'd1 && !pop) || cnt_r == 2'd2)) slot1_r <= res.item;
  end

endmodule

// File: hdl/binary_cross_morphology_filter.sv
// Streaming binary morphology filter with a four-neighbour cross window.
// Pixels enter in raster order at one per clock while the output buffer has
// space; a pixel's result is produced when the pixel one row below it is
// accepted and leaves through a two-entry output buffer, so the block keeps
// taking one item per cycle while a result waits. After the last pixel of a
// frame, one flush request per result drains the final row. The line store
// holds two rows split by column parity, each half read at two addresses a
// cycle one position ahead of the output counters. Sizes clamp to 1..MAX_WIDTH
// columns and 1..4096 rows. The user must write configuration between items;
// the block does not enforce it. Ready rises the cycle after reset.
module binary_cross_morphology_filter #(
  parameter int MAX_WIDTH = bcmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bcmf_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bcmf_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bcmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcmf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bcmf_pkg::*;

  cfg_t      cfg_r;
  logic      run_r;
  logic      space, accept;
  core_res_t res;

  assign cfg_ready = run_r;
  assign in_ready  = run_r && space;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r              <= 1'b0;
      cfg_r.mode         <= RESET_MODE;
      cfg_r.image_width  <= RESET_WIDTH;
      cfg_r.image_height <= RESET_HEIGHT;
    end else begin
      run_r <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE:   cfg_r.mode         <= cfg_data[MODE_W-1:0];
          CFG_WIDTH:  cfg_r.image_width  <= cfg_data[WIDTH_W-1:0];
          CFG_HEIGHT: cfg_r.image_height <= cfg_data[HEIGHT_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  bcmf_core #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (accept),
    .item   (in_data),
    .res    (res)
  );

  bcmf_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
